### rtl/core/sha1bs_pkg.sv
`default_nettype none

package sha1bs_pkg;

  // one 32-bit message word on its way to the compression unit
  typedef struct packed {
    logic [31:0] word;
    logic        fin;   // word 15 of the final block of a message
  } sha1bs_qword_t;

  typedef enum logic [1:0] {
    F_BYTES,
    F_FIRST,
    F_ZERO,
    F_LENLO
  } sha1bs_fstate_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_UPDATE,
    B_EMIT
  } sha1bs_bstate_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;
  localparam logic [3:0] LEN_WORD = 4'(LEN_POS / 4);

endpackage

`default_nettype wire

### rtl/core/sha1_byte_stream_hash.sv
// SHA-1 over a byte stream.
// Input: one word per message byte. in_tdata carries the byte, in_tuser says the
// byte is part of the message, in_tlast ends the message. A word with in_tlast
// and no byte ends the message as it stands (an empty message is allowed).
// Output: five words per message, digest words H0..H4 in order; out_tuser holds
// the word position, out_tlast marks the fifth.
// Throughput: the front takes one byte per cycle while it is in its byte state
// and its four-word queue has room. Each 64-byte block is loaded word by word
// into the compression unit, then runs through the rounds and one update; the
// load only partly overlaps the byte stream, as the queue fills during rounds.
// After the end word the front pushes 3 to 18 padding words, then one or two
// compressions run, and the first digest word is registered in the emit state
// after the final update; the rest follow one per cycle while out_tready is high.
// The front takes the next message while the digest is emitted, until its queue
// is full. A stalled out_tready holds the current digest word; the compression
// unit then waits and the queue backs up into in_tready.
// Reset (rst_n low, synchronous) loads the initial chaining value and clears
// the byte count and queue; no clearing pass is needed.
`default_nettype none

module sha1_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha1bs_pkg::*;

  sha1bs_qword_t push_data, pop_data;
  logic          push, pop, q_full, q_empty;

  sha1bs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .data_byte      (in_tdata),
    .byte_valid     (in_tuser),
    .end_of_message (in_tlast),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  sha1bs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sha1bs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### rtl/core/sha1bs_front.sv
`default_nettype none

module sha1bs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      byte_valid,
  input  logic                      end_of_message,
  input  logic                      q_full,
  output logic                      push,
  output sha1bs_pkg::sha1bs_qword_t push_data
);
  import sha1bs_pkg::*;

  sha1bs_fstate_t state_r, state_nxt;
  logic [63:0]    count_r, count_nxt;
  logic [31:0]    word_r, word_nxt;
  logic [3:0]     widx_r, widx_nxt;
  logic           extra_r, extra_nxt;
  logic [63:0]    bits;

  // big-endian placement of a byte at position p, later bytes zeroed
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] p,
                                           input logic [7:0] b);
    logic [31:0] r;
    case (p)
      2'd0:    r = {b, 24'h0};
      2'd1:    r = {w[31:24], b, 16'h0};
      2'd2:    r = {w[31:16], b, 8'h0};
      default: r = {w[31:8], b};
    endcase
    return r;
  endfunction

  assign bits     = {count_r[60:0], 3'b000};
  assign in_ready = (state_r == F_BYTES) && !q_full;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    word_nxt  = word_r;
    widx_nxt  = widx_r;
    extra_nxt = extra_r;
    push      = 1'b0;
    push_data = '{word: 32'h0, fin: 1'b0};
    unique case (state_r)
      F_BYTES: begin
        if (in_valid && in_ready) begin
          if (byte_valid) begin
            word_nxt  = put_byte(word_r, count_r[1:0], data_byte);
            count_nxt = count_r + 64'd1;
            if (count_r[1:0] == 2'd3) begin
              push      = 1'b1;
              push_data = '{word: word_nxt, fin: 1'b0};
            end
          end
          if (end_of_message) begin
            state_nxt = F_FIRST;
          end
        end
      end
      F_FIRST: begin
        if (!q_full) begin
          push      = 1'b1;
          push_data = '{word: put_byte(word_r, count_r[1:0], PAD_BYTE), fin: 1'b0};
          widx_nxt  = count_r[5:2] + 4'd1;
          // pad in word 14 needs one more zero word before wrapping
          extra_nxt = (count_r[5:2] == LEN_WORD);
          state_nxt = F_ZERO;
        end
      end
      F_ZERO: begin
        if (!q_full) begin
          push = 1'b1;
          if (widx_r == LEN_WORD && !extra_r) begin
            push_data = '{word: bits[63:32], fin: 1'b0};
            state_nxt = F_LENLO;
          end else begin
            push_data = '{word: 32'h0, fin: 1'b0};
            if (widx_r == 4'd15) begin
              extra_nxt = 1'b0;
            end
            widx_nxt = widx_r + 4'd1;
          end
        end
      end
      F_LENLO: begin
        if (!q_full) begin
          push      = 1'b1;
          push_data = '{word: bits[31:0], fin: 1'b1};
          count_nxt = 64'h0;
          state_nxt = F_BYTES;
        end
      end
      default: state_nxt = F_BYTES;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_BYTES;
      count_r <= 64'h0;
      widx_r  <= 4'h0;
      extra_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      widx_r  <= widx_nxt;
      extra_r <= extra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/sha1bs_queue.sv
`default_nettype none

module sha1bs_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  sha1bs_pkg::sha1bs_qword_t push_data,
  input  logic                      pop,
  output sha1bs_pkg::sha1bs_qword_t pop_data,
  output logic                      full,
  output logic                      empty
);
  import sha1bs_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  sha1bs_qword_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sha1bs_back.sv
`default_nettype none

module sha1bs_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  sha1bs_pkg::sha1bs_qword_t q_data,
  output logic                      pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,
  output logic [2:0]                out_tuser,
  output logic                      out_tlast
);
  import sha1bs_pkg::*;

  sha1bs_bstate_t state_r, state_nxt;
  logic [31:0] cv_r [5];
  logic [31:0] cv_nxt [5];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [2:0]  oi_r, oi_nxt;
  logic        ol_r, ol_nxt;
  logic [31:0] wt, f, k, tmp, mix;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // rounds 0..15 rotate the window; later rounds expand the schedule
  assign mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wt  = (cnt_r < 7'd16) ? w_r[0] : rotl(mix, 1);

  always_comb begin
    if (cnt_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (cnt_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (cnt_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
  end

  assign tmp = rotl(a_r, 5) + f + e_r + k + wt;

  always_comb begin
    state_nxt = state_r;
    cv_nxt    = cv_r;
    w_nxt     = w_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    ov_nxt    = ov_r && !out_tready;
    ow_nxt    = ow_r;
    oi_nxt    = oi_r;
    ol_nxt    = ol_r;
    pop       = 1'b0;
    unique case (state_r)
      B_LOAD: begin
        if (!q_empty) begin
          pop = 1'b1;
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[15] = q_data.word;
          cnt_nxt   = cnt_r + 7'd1;
          if (cnt_r == 7'd15) begin
            a_nxt     = cv_r[0];
            b_nxt     = cv_r[1];
            c_nxt     = cv_r[2];
            d_nxt     = cv_r[3];
            e_nxt     = cv_r[4];
            fin_nxt   = q_data.fin;
            cnt_nxt   = 7'd0;
            state_nxt = B_ROUND;
          end
        end
      end
      B_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = wt;
        a_nxt     = tmp;
        b_nxt     = a_r;
        c_nxt     = rotl(b_r, 30);
        d_nxt     = c_r;
        e_nxt     = d_r;
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          cnt_nxt   = 7'd0;
          state_nxt = B_UPDATE;
        end
      end
      B_UPDATE: begin
        cv_nxt[0] = cv_r[0] + a_r;
        cv_nxt[1] = cv_r[1] + b_r;
        cv_nxt[2] = cv_r[2] + c_r;
        cv_nxt[3] = cv_r[3] + d_r;
        cv_nxt[4] = cv_r[4] + e_r;
        state_nxt = fin_r ? B_EMIT : B_LOAD;
      end
      B_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt  = 1'b1;
          ow_nxt  = cv_r[cnt_r[2:0]];
          oi_nxt  = cnt_r[2:0];
          ol_nxt  = (cnt_r == 7'd4);
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd4) begin
            cv_nxt    = '{IV0, IV1, IV2, IV3, IV4};
            cnt_nxt   = 7'd0;
            state_nxt = B_LOAD;
          end
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      cnt_r   <= 7'd0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
      cv_r    <= '{IV0, IV1, IV2, IV3, IV4};
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
      cv_r    <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c_r  <= c_nxt;
    d_r  <= d_nxt;
    e_r  <= e_nxt;
    ow_r <= ow_nxt;
    oi_r <= oi_nxt;
    ol_r <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ow_r;
  assign out_tuser  = oi_r;
  assign out_tlast  = ol_r;

endmodule

`default_nettype wire
